>>> design/sjfq_pkg.sv
// ----------------------------------------------------------------------------
// sjfq_pkg
// Shared types and codes for the shortest-job-first ready queue.
// ----------------------------------------------------------------------------
package sjfq_pkg;

  // one queue entry as stored in the entry memory
  typedef struct packed {
    logic [15:0] burst;
    logic [15:0] id;
  } entry_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

>>> design/sjfq_ram.sv
// ----------------------------------------------------------------------------
// sjfq_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sjfq_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  sjfq_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output sjfq_pkg::entry_t rd_data
);
  import sjfq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/shortest_job_first_ready_queue_core.sv
// ----------------------------------------------------------------------------
// shortest_job_first_ready_queue_core
// Ready queue kept sorted by burst time, smallest burst at the head.
// ----------------------------------------------------------------------------
// Sequence: a pop reads the head entry, then registers it; an empty pop or a
//   rejected insert goes straight to the result; an insert walks from the tail
//   toward the head, shifting entries up, then writes the new entry in the gap.
// Throughput: one word at a time; next word is taken once the result is
//   registered, while that result still waits on the output side.
// Reset: synchronous, clears count, head pointer and handshakes; the memory
//   is not cleared (entries at or beyond the count are never read).
// ----------------------------------------------------------------------------
module shortest_job_first_ready_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] process_id,
  input  logic [15:0] burst_time,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  status,
  output logic        out_valid,
  output logic [15:0] out_process_id,
  output logic [15:0] out_burst_time,
  output logic [5:0]  occupancy
);
  import sjfq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    IDLE, DISPATCH, WALK, PLACE, POP, FINISH
  } state_t;

  state_t        state;
  logic [AW-1:0] head;      // physical address of logical position 0
  logic [CW-1:0] count;
  logic [AW-1:0] k;         // logical position whose entry is in rd_data
  logic          op_q;
  logic [15:0]   pid_q;
  logic [15:0]   burst_q;
  logic [1:0]    pend_status;
  logic          pend_valid;
  logic [15:0]   pend_id;
  logic [15:0]   pend_burst;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  entry_t        new_entry;
  logic          shift_up;

  // logical position -> physical address in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [AW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign in_ready  = (state == IDLE);
  assign new_entry = '{burst: burst_q, id: pid_q};
  // stored entry moves up one place when its burst is not below the new one
  assign shift_up  = (rd_data.burst >= burst_q);

  sjfq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = new_entry;
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      DISPATCH: begin
        if (op_q == OP_POP) begin
          rd_en = (count != '0);
        end else if (count == '0) begin
          wr_en = 1'b1;                       // empty queue: new head
        end else if (count != DEPTH_C) begin
          rd_en   = 1'b1;                     // start walk at the tail
          rd_addr = phys(head, AW'(count - 1'b1));
        end
      end
      WALK: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, k + 1'b1);
        if (shift_up) begin
          wr_data = rd_data;
          if (k != '0) begin
            rd_en   = 1'b1;
            rd_addr = phys(head, k - 1'b1);
          end
        end
      end
      PLACE: begin
        wr_en = 1'b1;                         // new entry at the head
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            op_q    <= operation;
            pid_q   <= process_id;
            burst_q <= burst_time;
            state   <= DISPATCH;
          end
        end
        DISPATCH: begin
          pend_valid <= 1'b0;
          pend_id    <= '0;
          pend_burst <= '0;
          if (op_q == OP_POP) begin
            if (count == '0) begin
              pend_status <= STATUS_EMPTY;
              state       <= FINISH;
            end else begin
              pend_status <= STATUS_OK;
              state       <= POP;
            end
          end else if (count == DEPTH_C) begin
            pend_status <= STATUS_FULL;
            state       <= FINISH;
          end else if (count == '0) begin
            pend_status <= STATUS_OK;
            count       <= count + 1'b1;
            state       <= FINISH;
          end else begin
            pend_status <= STATUS_OK;
            k           <= AW'(count - 1'b1);
            state       <= WALK;
          end
        end
        WALK: begin
          if (shift_up) begin
            if (k == '0) begin
              state <= PLACE;
            end else begin
              k <= k - 1'b1;
            end
          end else begin
            count <= count + 1'b1;
            state <= FINISH;
          end
        end
        PLACE: begin
          count <= count + 1'b1;
          state <= FINISH;
        end
        POP: begin
          pend_valid <= 1'b1;
          pend_id    <= rd_data.id;
          pend_burst <= rd_data.burst;
          head       <= phys(head, AW'(1));
          count      <= count - 1'b1;
          state      <= FINISH;
        end
        FINISH: begin
          // hand over once the result register is free
          if (!res_valid || res_ready) begin
            res_valid      <= 1'b1;
            status         <= pend_status;
            out_valid      <= pend_valid;
            out_process_id <= pend_id;
            out_burst_time <= pend_burst;
            occupancy      <= 6'(count);
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
